>>> rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and a helper function of the TEA block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

   localparam int WORD_WIDTH       = 32;
   localparam int ROUND_COUNT      = 32;
   localparam int STAGE_COUNT      = 2 * ROUND_COUNT;
   localparam int CSR_INDEX_WIDTH  = 3;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9e37_79b9;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_0   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_1   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_2   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_3   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECRYPT_MODE = 3'd4;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word_0;
      logic [WORD_WIDTH-1:0] word_1;
      logic [WORD_WIDTH-1:0] word_2;
      logic [WORD_WIDTH-1:0] word_3;
   } tea_key_type;

   typedef struct packed {
      logic                  decrypt;
      logic [WORD_WIDTH-1:0] first_word;
      logic [WORD_WIDTH-1:0] second_word;
   } tea_block_type;

   // delta times count, wrapped to one word
   function automatic logic [WORD_WIDTH-1:0] tea_round_sum(input int count);
      logic [2*WORD_WIDTH-1:0] product;
      product = {{WORD_WIDTH{1'b0}}, TEA_DELTA} * (2*WORD_WIDTH)'(count);
      return product[WORD_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/tea_cell.sv
// ----------------------------------------------------------------------------
// tea_cell
// One half round of TEA: updates one word of the block from the other and
// registers the block for the next cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  in_valid,
   input  tea_pkg::tea_block_type                in_block,
   input  logic [tea_pkg::WORD_WIDTH-1:0]        enc_sum,
   input  logic [tea_pkg::WORD_WIDTH-1:0]        dec_sum,
   input  logic                                  odd_half,
   input  tea_pkg::tea_key_type                  key,
   output logic                                  out_valid,
   output tea_pkg::tea_block_type                out_block
);
   import tea_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   tea_block_type         block_ff;
   tea_block_type         block_in;

   logic                  update_first;
   logic [WORD_WIDTH-1:0] mix_word;
   logic [WORD_WIDTH-1:0] target_word;
   logic [WORD_WIDTH-1:0] key_a;
   logic [WORD_WIDTH-1:0] key_b;
   logic [WORD_WIDTH-1:0] round_sum;
   logic [WORD_WIDTH-1:0] mix_value;
   logic [WORD_WIDTH-1:0] new_word;

   // encryption updates the first word on the even half, decryption on the odd
   assign update_first = odd_half ^ ~in_block.decrypt;

   always_comb begin
      mix_word    = update_first ? in_block.second_word : in_block.first_word;
      target_word = update_first ? in_block.first_word  : in_block.second_word;
      key_a       = update_first ? key.word_0 : key.word_2;
      key_b       = update_first ? key.word_1 : key.word_3;
      round_sum   = in_block.decrypt ? dec_sum : enc_sum;
      mix_value   = ((mix_word << 4) + key_a) ^ (mix_word + round_sum)
                  ^ ((mix_word >> 5) + key_b);
      new_word    = in_block.decrypt ? (target_word - mix_value)
                                     : (target_word + mix_value);
      block_in    = in_block;
      if (update_first) begin
         block_in.first_word = new_word;
      end else begin
         block_in.second_word = new_word;
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         block_ff <= block_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

`default_nettype wire

>>> rtl/tea_block_cipher_top.sv
// an accepted request passes through the cell chain (one cell per half round) to rsp_valid
// throughput: one block per cycle while rsp_ready stays high
// a result refused by rsp_ready parks in a hold register; the cell chain then
// stops and req_ready stays low until the held result is taken
// reset (synchronous) clears the key words, the mode and every valid bit
// ----------------------------------------------------------------------------
// tea_block_cipher_top
// TEA block cipher, 64-bit block and 128-bit key, built as a chain of
// half-round cells with a hold register on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [tea_pkg::WORD_WIDTH-1:0]          req_first_word,
   input  logic [tea_pkg::WORD_WIDTH-1:0]          req_second_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [tea_pkg::WORD_WIDTH-1:0]          rsp_out_first_word,
   output logic [tea_pkg::WORD_WIDTH-1:0]          rsp_out_second_word,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tea_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [tea_pkg::WORD_WIDTH-1:0]          csr_data
);
   import tea_pkg::*;

   tea_key_type   key_ff;
   tea_key_type   key_in;
   logic          decrypt_ff;
   logic          decrypt_in;

   logic          hold_valid_ff;
   logic          hold_valid_in;
   tea_block_type hold_block_ff;

   logic          chain_enable;
   logic          stage_valid [0:STAGE_COUNT];
   tea_block_type stage_block [0:STAGE_COUNT];
   tea_block_type last_block;
   logic          last_valid;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      key_in     = key_ff;
      decrypt_in = decrypt_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_WORD_0:   key_in.word_0 = csr_data;
            CSR_KEY_WORD_1:   key_in.word_1 = csr_data;
            CSR_KEY_WORD_2:   key_in.word_2 = csr_data;
            CSR_KEY_WORD_3:   key_in.word_3 = csr_data;
            CSR_DECRYPT_MODE: decrypt_in    = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         decrypt_ff <= 1'b0;
      end else begin
         key_ff     <= key_in;
         decrypt_ff <= decrypt_in;
      end
   end

   // cell chain
   assign chain_enable = ~hold_valid_ff;
   assign req_ready    = chain_enable;

   assign stage_valid[0]             = req_valid;
   assign stage_block[0].decrypt     = decrypt_ff;
   assign stage_block[0].first_word  = req_first_word;
   assign stage_block[0].second_word = req_second_word;

   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_cell
      localparam logic [WORD_WIDTH-1:0] ENC_SUM = tea_round_sum(s / 2 + 1);
      localparam logic [WORD_WIDTH-1:0] DEC_SUM = tea_round_sum(ROUND_COUNT - s / 2);
      localparam logic                  ODD     = 1'(s % 2);

      tea_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (chain_enable),
         .in_valid  (stage_valid[s]),
         .in_block  (stage_block[s]),
         .enc_sum   (ENC_SUM),
         .dec_sum   (DEC_SUM),
         .odd_half  (ODD),
         .key       (key_ff),
         .out_valid (stage_valid[s+1]),
         .out_block (stage_block[s+1])
      );
   end

   assign last_valid = stage_valid[STAGE_COUNT];
   assign last_block = stage_block[STAGE_COUNT];

   // result side: a refused transaction moves into the hold register
   always_comb begin
      if (hold_valid_ff) begin
         hold_valid_in = ~rsp_ready;
      end else begin
         hold_valid_in = last_valid & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_valid_ff) begin
         hold_block_ff <= last_block;
      end
   end

   assign rsp_valid           = hold_valid_ff | last_valid;
   assign rsp_out_first_word  = hold_valid_ff ? hold_block_ff.first_word
                                              : last_block.first_word;
   assign rsp_out_second_word = hold_valid_ff ? hold_block_ff.second_word
                                              : last_block.second_word;

   // checks
   a_hold_from_refused: assert property (@(posedge clock) disable iff (reset)
      $rose(hold_valid_ff) |-> $past(last_valid && !rsp_ready))
      else $error("hold register filled without a refused result");

   a_hold_data_stable: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && $past(hold_valid_ff) |-> $stable(hold_block_ff))
      else $error("held result changed");

   a_hold_drains: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && rsp_ready |=> !hold_valid_ff)
      else $error("hold register not emptied after transaction");

   a_first_stage_mode: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage_valid[1]
                                 && stage_block[1].decrypt == $past(decrypt_ff))
      else $error("accepted block lost or wrong mode in first cell");

endmodule

`default_nettype wire

>>> tb/tea_cipher_check_pkg.sv
// ----------------------------------------------------------------------------
// tea_cipher_check_pkg
// Scoreboard for the TEA block cipher bench: keeps its own copy of the key
// and mode, works out each block's expected cipher result when the block is
// accepted, and compares returned blocks against those results in order.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_cipher_check_pkg;

   import tea_pkg::*;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type first_word;
      word_type second_word;
   } tea_words_type;

   class tea_cipher_scoreboard;

      word_type      key_words [4];
      logic          decrypt_on;
      tea_words_type expected_blocks [$];
      int            error_count;

      function new();
         foreach (key_words[i]) key_words[i] = '0;
         decrypt_on  = 1'b0;
         error_count = 0;
      endfunction

      // mirror of a register write, unknown indexes fall through
      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index, word_type data);
         case (index)
            CSR_KEY_WORD_0:   key_words[0] = data;
            CSR_KEY_WORD_1:   key_words[1] = data;
            CSR_KEY_WORD_2:   key_words[2] = data;
            CSR_KEY_WORD_3:   key_words[3] = data;
            CSR_DECRYPT_MODE: decrypt_on   = data[0];
            default: ;
         endcase
      endfunction

      function word_type round_mix(word_type w, word_type sum, word_type ka, word_type kb);
         return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
      endfunction

      function tea_words_type cipher_block(word_type first_word, word_type second_word);
         word_type      a;
         word_type      b;
         word_type      sum;
         tea_words_type result;
         a   = first_word;
         b   = second_word;
         sum = '0;
         if (!decrypt_on) begin
            for (int r = 0; r < ROUND_COUNT; r++) begin
               sum = sum + TEA_DELTA;
               a   = a + round_mix(b, sum, key_words[0], key_words[1]);
               b   = b + round_mix(a, sum, key_words[2], key_words[3]);
            end
         end else begin
            // start from delta times the round count, wrapped
            for (int r = 0; r < ROUND_COUNT; r++) sum = sum + TEA_DELTA;
            for (int r = 0; r < ROUND_COUNT; r++) begin
               b   = b - round_mix(a, sum, key_words[2], key_words[3]);
               a   = a - round_mix(b, sum, key_words[0], key_words[1]);
               sum = sum - TEA_DELTA;
            end
         end
         result.first_word  = a;
         result.second_word = b;
         return result;
      endfunction

      function void note_block(word_type first_word, word_type second_word);
         expected_blocks.push_back(cipher_block(first_word, second_word));
      endfunction

      function void check_block(word_type out_first_word, word_type out_second_word);
         tea_words_type want;
         if (expected_blocks.size() == 0) begin
            $error("result transaction with nothing expected: %h %h",
                   out_first_word, out_second_word);
            error_count++;
            return;
         end
         want = expected_blocks.pop_front();
         if (out_first_word !== want.first_word) begin
            $error("out_first_word: expected %h, actual %h",
                   want.first_word, out_first_word);
            error_count++;
         end
         if (out_second_word !== want.second_word) begin
            $error("out_second_word: expected %h, actual %h",
                   want.second_word, out_second_word);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_blocks.size();
      endfunction

      function void report_leftover();
         if (expected_blocks.size() != 0) begin
            $error("%0d expected results never arrived", expected_blocks.size());
            error_count++;
         end
      endfunction

   endclass

endpackage

`default_nettype wire

>>> tb/tb_tea_block_cipher_top.sv
// ----------------------------------------------------------------------------
// tb_tea_block_cipher_top
// Self-checking bench for the TEA block cipher: directed corner blocks under
// fixed keys and both modes, then random blocks under random keys, with
// bursty input traffic, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tea_block_cipher_top;

   timeunit 1ns;
   timeprecision 1ps;

   import tea_pkg::*;
   import tea_cipher_check_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_BLOCKS    = 200;
   localparam int HOLD_OFF_CYCLES = 400;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   word_type                   req_first_word = '0;
   word_type                   req_second_word = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   word_type                   rsp_out_first_word;
   word_type                   rsp_out_second_word;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   word_type                   csr_data = '0;

   tea_cipher_scoreboard cipher_board = new();

   int unsigned cycle_count = 0;
   int          hold_request = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          stall_style = 0;
   int          burst_left = 0;

   tea_block_cipher_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_first_word      (req_first_word),
      .req_second_word     (req_second_word),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_first_word  (rsp_out_first_word),
      .rsp_out_second_word (rsp_out_second_word),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_tea_block_cipher_top: done, errors");
         $finish;
      end
   end

   // all block state moves on nonblocking updates, so these see pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) cipher_board.write_register(csr_index, csr_data);
         if (req_valid && req_ready) cipher_board.note_block(req_first_word, req_second_word);
         if (rsp_valid && rsp_ready)
            cipher_board.check_block(rsp_out_first_word, rsp_out_second_word);
      end
   end

   // receiver: changing stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) stall_style <= $urandom_range(0, 3);
      if (hold_seen != hold_request) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ((cycle_count % 16) < 11);
            default: rsp_ready <= $urandom_range(0, 1);
         endcase
      end
   end

   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return word_type'(1) << $urandom_range(0, WORD_WIDTH - 1);
         default: return $urandom;
      endcase
   endfunction

   // leaves valid high at the accepting edge
   task automatic send_block(input word_type first_word, input word_type second_word);
      req_valid       <= 1'b1;
      req_first_word  <= first_word;
      req_second_word <= second_word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // bursts of random length with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   task automatic csr_put(input logic [CSR_INDEX_WIDTH-1:0] index, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input word_type k0, input word_type k1,
                                 input word_type k2, input word_type k3,
                                 input word_type mode_data);
      csr_put(CSR_KEY_WORD_0, k0);
      csr_put(CSR_KEY_WORD_1, k1);
      csr_put(CSR_KEY_WORD_2, k2);
      csr_put(CSR_KEY_WORD_3, k3);
      csr_put(CSR_DECRYPT_MODE, mode_data);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cipher_board.pending() != 0) @(posedge clock);
   endtask

   task automatic send_corner_blocks();
      send_block('0, '0);
      send_block('1, '1);
      send_block(32'h8000_0000, 32'h0000_0001);
      send_block(32'h0000_0001, 32'h8000_0000);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // key all zero, encrypt, straight out of reset
      send_corner_blocks();
      wait_idle();

      // all-ones key; writes to unused indexes must not land anywhere
      write_settings('1, '1, '1, '1, '0);
      for (int i = CSR_DECRYPT_MODE + 1; i < 2 ** CSR_INDEX_WIDTH; i++)
         csr_put(CSR_INDEX_WIDTH'(i), 32'h5a5a_a5a5);
      csr_release();
      send_corner_blocks();
      wait_idle();

      // decrypt, mode data with upper bits set
      write_settings(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210,
                     32'hffff_ffff);
      csr_release();
      send_corner_blocks();
      wait_idle();

      // only bit 0 of the mode counts: this is encrypt
      write_settings('0, '1, '0, '1, 32'h0000_0002);
      csr_release();
      send_corner_blocks();
      wait_idle();

      write_settings('1, '0, '1, '0, 32'h0000_0001);
      csr_release();
      send_corner_blocks();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         write_settings(rand_word(), rand_word(), rand_word(), rand_word(), $urandom);
         csr_release();
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            // long receiver hold-off while input keeps coming, fills the chain
            if (phase == 2 && n == 40) hold_request = hold_request + 1;
            send_block(rand_word(), rand_word());
            pace_sender();
         end
      end

      wait_idle();
      repeat (2 * STAGE_COUNT) @(posedge clock);
      cipher_board.report_leftover();
      if (cipher_board.error_count == 0) begin
         $display("tb_tea_block_cipher_top: done, clean");
      end else begin
         $display("tb_tea_block_cipher_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
